// ----- design/gabd_pkg.sv -----
`default_nettype none
package gabd_pkg;

    localparam int LCD_QUEUE_DEPTH = 20;
    localparam int PAGE_BITS       = 14;

    localparam int QCNT_W = $clog2(LCD_QUEUE_DEPTH + 1);
    localparam int QIDX_W = (LCD_QUEUE_DEPTH > 1) ? $clog2(LCD_QUEUE_DEPTH) : 1;
    localparam int RAM_AW = PAGE_BITS + 1;
    localparam int RAM_DEPTH = 1 << RAM_AW;

    localparam logic [8:0] HI_ROM_LO   = 9'h020;
    localparam logic [8:0] HI_BANK_LO  = 9'h100;
    localparam logic [8:0] HI_RAM_LO   = 9'h180;
    localparam logic [8:0] HI_SYNTH_LO = 9'h018;
    localparam logic [8:0] HI_BANK_REG = 9'h002;
    localparam logic [8:0] HI_BUTTONS  = 9'h004;
    localparam logic [8:0] HI_LCD_DATA = 9'h006;
    localparam logic [8:0] HI_LCD_CTRL = 9'h007;

    localparam logic [6:0] POS_ROW0_END = 7'd10;
    localparam logic [6:0] POS_ROW1_LO  = 7'd64;
    localparam logic [6:0] POS_ROW1_END = 7'd74;

    localparam logic       REQ_WRITE = 1'b1;

    typedef enum logic [2:0] {
        KIND_DONE     = 3'd0,
        KIND_READ     = 3'd1,
        KIND_ROM      = 3'd2,
        KIND_SYNTH_RD = 3'd3,
        KIND_SYNTH_WR = 3'd4,
        KIND_LCD      = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FLUSH
    } t_state;

endpackage
`default_nettype wire

// ----- design/gabd_ram.sv -----
`default_nettype none
module gabd_ram (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire                          i_re,
    input  wire [gabd_pkg::RAM_AW-1:0]   i_addr,
    input  wire [7:0]                    i_wdata,
    output logic [7:0]                   o_rdata
);

    logic [7:0] r_mem [gabd_pkg::RAM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule
`default_nettype wire

// ----- design/gate_array_bus_decoder_unit.sv -----
`default_nettype none
// Bus decoder for one CPU access per request. Most requests register their
// result directly; a read of the internal RAM or of a RAM page in the banked
// window first passes the registered read of the 32 KiB work RAM and the READ
// state. A write to the LCD control port with a valid cursor position sends the
// control byte and then walks the LCD queue one byte a cycle while the output
// register is free, up to 20 queued bytes. A new request is taken only in idle
// and only when the output register is empty or its result is accepted in that
// same cycle, so a result that waits on m_axis_tready holds off the input.
// Never-written RAM bytes read as whatever the RAM holds.
module gate_array_bus_decoder_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // address[15:0], write_data[23:16], buttons[33:24], lcd_busy[34], zero[39:35]
    input  wire [39:0]  s_axis_tdata,
    // req_type[0]
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // out_data[7:0], ext_address[24:8], zero[31:25]
    output logic [31:0] m_axis_tdata,
    // kind[2:0], lcd_rs[3]
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int QCNT_W = gabd_pkg::QCNT_W;
    localparam int QIDX_W = gabd_pkg::QIDX_W;
    localparam int RAM_AW = gabd_pkg::RAM_AW;
    localparam int PB     = gabd_pkg::PAGE_BITS;

    gabd_pkg::t_state r_state, n_state;
    logic               r_m_valid, n_m_valid;
    gabd_pkg::t_kind    r_kind, n_kind;
    logic [7:0]         r_data, n_data;
    logic [16:0]        r_ext, n_ext;
    logic               r_rs, n_rs;
    logic               r_last, n_last;
    logic [4:0]         r_bank, n_bank;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic [QCNT_W-1:0]  r_flush_cnt, n_flush_cnt;
    logic [QCNT_W-1:0]  r_idx, n_idx;
    logic [7:0]         r_queue [gabd_pkg::LCD_QUEUE_DEPTH];

    logic               w_req_write;
    logic [15:0]        w_addr;
    logic [7:0]         w_wdata;
    logic [9:0]         w_buttons;
    logic               w_busy;
    logic [8:0]         w_hi;
    logic               w_accept;
    logic               w_out_free;
    logic               w_is_rom, w_is_bank, w_is_ram, w_is_synth;
    logic [6:0]         w_pos;
    logic               w_pos_ok;
    logic [7:0]         w_btn_val;
    logic               q_we;
    logic               ram_we, ram_re;
    logic [RAM_AW-1:0]  ram_addr;
    logic [7:0]         ram_rdata;

    assign w_req_write = (s_axis_tuser == gabd_pkg::REQ_WRITE);
    assign w_addr      = s_axis_tdata[15:0];
    assign w_wdata     = s_axis_tdata[23:16];
    assign w_buttons   = s_axis_tdata[33:24];
    assign w_busy      = s_axis_tdata[34];
    assign w_hi        = w_addr[15:7];

    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == gabd_pkg::ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_is_rom   = (w_hi >= gabd_pkg::HI_ROM_LO) && (w_hi < gabd_pkg::HI_BANK_LO);
    assign w_is_bank  = (w_hi >= gabd_pkg::HI_BANK_LO) && (w_hi < gabd_pkg::HI_RAM_LO);
    assign w_is_ram   = (w_hi >= gabd_pkg::HI_RAM_LO);
    assign w_is_synth = (w_hi >= gabd_pkg::HI_SYNTH_LO) && (w_hi < gabd_pkg::HI_ROM_LO);

    assign w_pos    = w_wdata[6:0];
    assign w_pos_ok = (w_pos < gabd_pkg::POS_ROW0_END)
                   || ((w_pos >= gabd_pkg::POS_ROW1_LO) && (w_pos < gabd_pkg::POS_ROW1_END));

    always_comb begin
        w_btn_val = 8'hff;
        if (!w_addr[2]) begin
            w_btn_val = w_btn_val & ~{3'b000, w_buttons[4:0]};
        end
        if (!w_addr[1]) begin
            w_btn_val = w_btn_val & ~{3'b000, w_buttons[9:5]};
        end
    end

    always_comb begin
        if (w_is_ram) begin
            ram_addr = {1'b0, w_addr[PB-1:0]};
        end else begin
            ram_addr = {r_bank[0], w_addr[PB-1:0]};
        end
    end

    assign ram_we = w_accept && w_req_write && (w_is_ram || (w_is_bank && r_bank[4]));
    assign ram_re = w_accept && !w_req_write && (w_is_ram || (w_is_bank && r_bank[4]));

    gabd_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (w_wdata),
        .o_rdata (ram_rdata)
    );

    assign q_we = w_accept && w_req_write && (w_hi == gabd_pkg::HI_LCD_DATA)
               && (r_count < QCNT_W'(gabd_pkg::LCD_QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue[r_count[QIDX_W-1:0]] <= w_wdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_m_valid   = r_m_valid;
        n_kind      = r_kind;
        n_data      = r_data;
        n_ext       = r_ext;
        n_rs        = r_rs;
        n_last      = r_last;
        n_bank      = r_bank;
        n_count     = r_count;
        n_flush_cnt = r_flush_cnt;
        n_idx       = r_idx;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            gabd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_m_valid = 1'b1;
                    n_kind    = gabd_pkg::KIND_DONE;
                    n_data    = 8'h00;
                    n_ext     = 17'h00000;
                    n_rs      = 1'b0;
                    n_last    = 1'b1;
                    if (!w_req_write) begin
                        n_kind = gabd_pkg::KIND_READ;
                        if (w_is_rom) begin
                            n_kind = gabd_pkg::KIND_ROM;
                            n_ext  = {1'b0, w_addr};
                        end else if (w_is_ram || (w_is_bank && r_bank[4])) begin
                            n_m_valid = 1'b0;
                            n_state   = gabd_pkg::ST_READ;
                        end else if (w_is_bank) begin
                            n_kind = gabd_pkg::KIND_ROM;
                            n_ext  = {r_bank[2:0], w_addr[PB-1:0]};
                        end else if (w_is_synth) begin
                            n_kind = gabd_pkg::KIND_SYNTH_RD;
                            n_ext  = {8'h00, w_addr[8:0]};
                        end else if (w_hi == gabd_pkg::HI_LCD_CTRL) begin
                            n_data = {7'h00, w_busy};
                        end else if (w_hi == gabd_pkg::HI_BUTTONS) begin
                            n_data = w_btn_val;
                        end else begin
                            n_data = 8'hff;
                        end
                    end else begin
                        if (w_is_synth) begin
                            n_kind = gabd_pkg::KIND_SYNTH_WR;
                            n_data = w_wdata;
                            n_ext  = {8'h00, w_addr[8:0]};
                        end else if (w_hi == gabd_pkg::HI_BANK_REG) begin
                            n_bank = w_wdata[4:0];
                        end else if (q_we) begin
                            n_count = r_count + 1'b1;
                        end else if (w_hi == gabd_pkg::HI_LCD_CTRL) begin
                            n_count = '0;
                            if (!w_wdata[7] || w_pos_ok) begin
                                n_kind = gabd_pkg::KIND_LCD;
                                n_data = w_wdata;
                                n_last = !w_wdata[7] || (r_count == '0);
                            end
                            if (w_wdata[7] && w_pos_ok && (r_count != '0)) begin
                                n_flush_cnt = r_count;
                                n_idx       = '0;
                                n_state     = gabd_pkg::ST_FLUSH;
                            end
                        end
                    end
                end
            end
            gabd_pkg::ST_READ: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_kind    = gabd_pkg::KIND_READ;
                    n_data    = ram_rdata;
                    n_ext     = 17'h00000;
                    n_rs      = 1'b0;
                    n_last    = 1'b1;
                    n_state   = gabd_pkg::ST_IDLE;
                end
            end
            gabd_pkg::ST_FLUSH: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_kind    = gabd_pkg::KIND_LCD;
                    n_data    = r_queue[r_idx[QIDX_W-1:0]];
                    n_ext     = 17'h00000;
                    n_rs      = 1'b1;
                    n_last    = (r_idx + 1'b1) == r_flush_cnt;
                    n_idx     = r_idx + 1'b1;
                    if ((r_idx + 1'b1) == r_flush_cnt) begin
                        n_state = gabd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = gabd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gabd_pkg::ST_IDLE;
            r_m_valid <= 1'b0;
            r_bank    <= 5'd0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_bank    <= n_bank;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_data      <= n_data;
        r_ext       <= n_ext;
        r_rs        <= n_rs;
        r_last      <= n_last;
        r_flush_cnt <= n_flush_cnt;
        r_idx       <= n_idx;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'h00, r_ext, r_data};
    assign m_axis_tuser  = {r_rs, r_kind};
    assign m_axis_tlast  = r_last;

endmodule
`default_nettype wire

// ----- test/gate_array_bus_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
module gate_array_bus_decoder_unit_tb;

    localparam logic REQ_READ  = ~gabd_pkg::REQ_WRITE;
    localparam int   RUN_LIMIT = 200000;
    localparam int   DRAIN_CYC = 30;

    typedef struct {
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [9:0]  btn;
        logic        busy;
    } t_bus_req;

    typedef struct {
        gabd_pkg::t_kind kind;
        logic [7:0]      data;
        logic [16:0]     ext;
        logic            rs;
        logic            last;
    } t_bus_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    // address[15:0], write_data[23:16], buttons[33:24], lcd_busy[34], zero[39:35]
    logic [39:0] s_axis_tdata = '0;
    // req_type[0]
    logic        s_axis_tuser = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_data[7:0], ext_address[24:8], zero[31:25]
    wire  [31:0] m_axis_tdata;
    // kind[2:0], lcd_rs[3]
    wire  [3:0]  m_axis_tuser;
    wire         m_axis_tlast;

    gate_array_bus_decoder_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_bus_req    access_q[$];
    t_bus_result decoded_q[$];
    int          err_cnt = 0;
    int          acc_cnt = 0;
    int          cyc_cnt = 0;
    int          req_total = 0;

    // predictor state
    logic [7:0]  ram_img [gabd_pkg::RAM_DEPTH];
    logic [4:0]  bank_img = '0;
    logic [7:0]  lcd_img[$];

    // stimulus-side shadow, used to keep reads off never-written RAM
    logic [4:0]  gen_bank = '0;
    bit          ram_seen [gabd_pkg::RAM_DEPTH];
    int          seen_lo[$];
    int          seen_hi[$];

    always @(posedge i_clk) cyc_cnt <= cyc_cnt + 1;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic void queue_result(gabd_pkg::t_kind k, logic [7:0] d, logic [16:0] e,
                                         logic rs, logic last);
        t_bus_result res;
        res.kind = k;
        res.data = d;
        res.ext  = e;
        res.rs   = rs;
        res.last = last;
        decoded_q.push_back(res);
    endfunction

    function automatic void decode_access(t_bus_req r);
        logic [8:0]  hi;
        logic [14:0] phys;
        logic [7:0]  v;
        logic [6:0]  pos;
        int          n;
        hi   = r.addr[15:7];
        phys = {1'b0, r.addr[13:0]};
        if (r.wr != gabd_pkg::REQ_WRITE) begin
            if (hi >= gabd_pkg::HI_ROM_LO && hi < gabd_pkg::HI_BANK_LO) begin
                queue_result(gabd_pkg::KIND_ROM, 8'h00, {1'b0, r.addr}, 1'b0, 1'b1);
            end else if (hi >= gabd_pkg::HI_RAM_LO) begin
                queue_result(gabd_pkg::KIND_READ, ram_img[phys], '0, 1'b0, 1'b1);
            end else if (hi >= gabd_pkg::HI_BANK_LO) begin
                if (bank_img[4]) begin
                    queue_result(gabd_pkg::KIND_READ, ram_img[{bank_img[0], r.addr[13:0]}],
                                 '0, 1'b0, 1'b1);
                end else begin
                    queue_result(gabd_pkg::KIND_ROM, 8'h00, {bank_img[2:0], r.addr[13:0]},
                                 1'b0, 1'b1);
                end
            end else if (hi >= gabd_pkg::HI_SYNTH_LO) begin
                queue_result(gabd_pkg::KIND_SYNTH_RD, 8'h00, {8'h00, r.addr[8:0]}, 1'b0, 1'b1);
            end else if (hi == gabd_pkg::HI_LCD_CTRL) begin
                queue_result(gabd_pkg::KIND_READ, {7'h00, r.busy}, '0, 1'b0, 1'b1);
            end else if (hi == gabd_pkg::HI_BUTTONS) begin
                v = 8'hff;
                if (!r.addr[2]) v = v & ~{3'b000, r.btn[4:0]};
                if (!r.addr[1]) v = v & ~{3'b000, r.btn[9:5]};
                queue_result(gabd_pkg::KIND_READ, v, '0, 1'b0, 1'b1);
            end else begin
                queue_result(gabd_pkg::KIND_READ, 8'hff, '0, 1'b0, 1'b1);
            end
            return;
        end
        if (hi >= gabd_pkg::HI_RAM_LO) begin
            ram_img[phys] = r.wdata;
        end else if (hi >= gabd_pkg::HI_BANK_LO) begin
            if (bank_img[4]) ram_img[{bank_img[0], r.addr[13:0]}] = r.wdata;
        end else if (hi >= gabd_pkg::HI_ROM_LO) begin
            // ROM space: nothing to store
        end else if (hi >= gabd_pkg::HI_SYNTH_LO) begin
            queue_result(gabd_pkg::KIND_SYNTH_WR, r.wdata, {8'h00, r.addr[8:0]}, 1'b0, 1'b1);
            return;
        end else if (hi == gabd_pkg::HI_BANK_REG) begin
            bank_img = r.wdata[4:0];
        end else if (hi == gabd_pkg::HI_LCD_DATA) begin
            if (lcd_img.size() < gabd_pkg::LCD_QUEUE_DEPTH) lcd_img.push_back(r.wdata);
        end else if (hi == gabd_pkg::HI_LCD_CTRL) begin
            n   = lcd_img.size();
            pos = r.wdata[6:0];
            if (!r.wdata[7]) begin
                lcd_img.delete();
                queue_result(gabd_pkg::KIND_LCD, r.wdata, '0, 1'b0, 1'b1);
                return;
            end
            if (pos < gabd_pkg::POS_ROW0_END ||
                (pos >= gabd_pkg::POS_ROW1_LO && pos < gabd_pkg::POS_ROW1_END)) begin
                queue_result(gabd_pkg::KIND_LCD, r.wdata, '0, 1'b0, n == 0);
                for (int i = 0; i < n; i++)
                    queue_result(gabd_pkg::KIND_LCD, lcd_img[i], '0, 1'b1, i == n - 1);
                lcd_img.delete();
                return;
            end
            lcd_img.delete();
        end
        queue_result(gabd_pkg::KIND_DONE, 8'h00, '0, 1'b0, 1'b1);
    endfunction

    function automatic int phys_index(logic [15:0] a, logic [4:0] bk);
        if (a[15:14] == 2'b11) return int'(a[13:0]);
        if (a[15:14] == 2'b10 && bk[4]) return int'({bk[0], a[13:0]});
        return -1;
    endfunction

    task automatic add_req(logic wr, logic [15:0] a, logic [7:0] d, logic [9:0] btn,
                           logic busy);
        t_bus_req    r;
        int          idx;
        logic [14:0] p;
        idx = phys_index(a, gen_bank);
        if (wr == REQ_READ && idx >= 0 && !ram_seen[idx]) begin
            if (gen_bank[4] && gen_bank[0] && seen_hi.size() > 0 &&
                (seen_lo.size() == 0 || $urandom_range(0, 1))) begin
                p = 15'(seen_hi[$urandom_range(0, seen_hi.size() - 1)]);
                a = {2'b10, p[13:0]};
            end else if (seen_lo.size() > 0) begin
                p = 15'(seen_lo[$urandom_range(0, seen_lo.size() - 1)]);
                if (gen_bank[4] && !gen_bank[0] && $urandom_range(0, 1))
                    a = {2'b10, p[13:0]};
                else
                    a = {2'b11, p[13:0]};
            end else begin
                wr = gabd_pkg::REQ_WRITE;
            end
        end
        if (wr == gabd_pkg::REQ_WRITE) begin
            if (idx >= 0 && !ram_seen[idx]) begin
                ram_seen[idx] = 1'b1;
                if (idx < (1 << gabd_pkg::PAGE_BITS)) seen_lo.push_back(idx);
                else seen_hi.push_back(idx);
            end
            if (a[15:7] == gabd_pkg::HI_BANK_REG) gen_bank = d[4:0];
        end
        r.wr    = wr;
        r.addr  = a;
        r.wdata = d;
        r.btn   = btn;
        r.busy  = busy;
        access_q.push_back(r);
    endtask

    task automatic add_rnd(logic wr, logic [15:0] a);
        add_req(wr, a, 8'($urandom), 10'($urandom), 1'($urandom));
    endtask

    function automatic logic [7:0] valid_cursor();
        int pos;
        pos = $urandom_range(0, 19);
        if (pos >= 10) pos = pos + 54;
        return 8'h80 | 8'(pos);
    endfunction

    task automatic build_directed();
        add_rnd(gabd_pkg::REQ_WRITE, 16'hc000);
        add_req(gabd_pkg::REQ_WRITE, 16'hffff, 8'hff, 10'h000, 1'b0);
        add_rnd(REQ_READ, 16'hc000);
        add_rnd(REQ_READ, 16'hffff);
        add_req(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_BANK_REG, 7'h00}, 8'hff, 10'h3ff, 1'b1);
        add_req(gabd_pkg::REQ_WRITE, 16'h8000, 8'ha5, 10'h000, 1'b0);
        add_req(gabd_pkg::REQ_WRITE, 16'hbfff, 8'h5a, 10'h000, 1'b0);
        add_rnd(REQ_READ, 16'h8000);
        add_rnd(REQ_READ, 16'hbfff);
        add_req(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_BANK_REG, 7'h7f}, 8'h07, 10'h000, 1'b0);
        add_rnd(REQ_READ, 16'hbfff);
        add_rnd(gabd_pkg::REQ_WRITE, 16'h9234);
        add_rnd(REQ_READ, 16'h1000);
        add_rnd(REQ_READ, 16'h0c00);
        add_req(gabd_pkg::REQ_WRITE, 16'h0fff, 8'h3c, 10'h000, 1'b0);
        add_req(REQ_READ, {gabd_pkg::HI_LCD_CTRL, 7'h00}, 8'h00, 10'h000, 1'b1);
        add_req(REQ_READ, {gabd_pkg::HI_BUTTONS, 7'h00}, 8'h00, 10'h3ff, 1'b0);
        add_req(REQ_READ, {gabd_pkg::HI_BUTTONS, 7'h02}, 8'h00, 10'h155, 1'b0);
        add_req(REQ_READ, {gabd_pkg::HI_BUTTONS, 7'h04}, 8'h00, 10'h2aa, 1'b0);
        add_req(REQ_READ, {gabd_pkg::HI_BUTTONS, 7'h06}, 8'h00, 10'h3ff, 1'b0);
        add_rnd(REQ_READ, 16'h0000);
        add_rnd(gabd_pkg::REQ_WRITE, 16'h0bff);
        add_req(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_LCD_DATA, 7'h00}, 8'h41, 10'h000, 1'b0);
        add_req(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_LCD_CTRL, 7'h7f}, 8'hca, 10'h000, 1'b0);
        add_req(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_LCD_CTRL, 7'h00}, 8'h01, 10'h000, 1'b0);
        add_req(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_LCD_CTRL, 7'h00}, 8'h80, 10'h000, 1'b0);
    endtask

    task automatic add_lcd_burst(int n);
        logic [7:0] d;
        for (int i = 0; i < n; i++)
            add_rnd(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_LCD_DATA, 7'($urandom)});
        case ($urandom_range(0, 5))
            0: d = 8'($urandom_range(0, 127));
            1: begin
                d = 8'($urandom_range(10, 117));
                if (d >= 64) d = d + 10;
                d = d | 8'h80;
            end
            default: d = valid_cursor();
        endcase
        add_req(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_LCD_CTRL, 7'($urandom)}, d, 10'($urandom),
                1'($urandom));
    endtask

    task automatic build_random(int target);
        int          base;
        logic [15:0] a;
        logic [7:0]  d;
        logic [8:0]  hi;
        base = access_q.size();
        for (int i = 0; i < gabd_pkg::LCD_QUEUE_DEPTH + 2; i++)
            add_rnd(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_LCD_DATA, 7'($urandom)});
        add_req(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_LCD_CTRL, 7'h00}, 8'hc9, 10'h000, 1'b0);
        while (access_q.size() - base < target) begin
            case ($urandom_range(0, 9))
                0: add_rnd(1'($urandom), 16'($urandom));
                1: add_lcd_burst($urandom_range(0, gabd_pkg::LCD_QUEUE_DEPTH + 3));
                2: begin
                    d = 8'($urandom);
                    if ($urandom_range(0, 2) != 0) d[4] = 1'b1;
                    add_req(gabd_pkg::REQ_WRITE, {gabd_pkg::HI_BANK_REG, 7'($urandom)}, d,
                            10'($urandom), 1'($urandom));
                    repeat ($urandom_range(1, 4)) add_rnd(1'($urandom), {2'b10, 14'($urandom)});
                end
                3: begin
                    a = {1'b1, 1'($urandom), 14'($urandom)};
                    add_rnd(gabd_pkg::REQ_WRITE, a);
                    add_rnd(REQ_READ, a);
                end
                4: add_rnd(REQ_READ, {9'($urandom_range(gabd_pkg::HI_ROM_LO,
                                                        gabd_pkg::HI_BANK_LO - 1)),
                                      7'($urandom)});
                5: add_rnd(1'($urandom), {9'($urandom_range(gabd_pkg::HI_SYNTH_LO,
                                                            gabd_pkg::HI_ROM_LO - 1)),
                                          7'($urandom)});
                6: add_rnd(REQ_READ, {gabd_pkg::HI_BUTTONS, 7'($urandom)});
                7: add_rnd(1'($urandom), {gabd_pkg::HI_LCD_CTRL, 7'($urandom)});
                8: begin
                    case ($urandom_range(0, 4))
                        0: hi = 9'h000;
                        1: hi = 9'h001;
                        2: hi = 9'h003;
                        3: hi = 9'h005;
                        default: hi = 9'($urandom_range(8, 9'h017));
                    endcase
                    add_rnd(1'($urandom), {hi, 7'($urandom)});
                end
                default: add_rnd(1'($urandom), {1'b1, 1'($urandom), 14'($urandom)});
            endcase
        end
    endtask

    // request side
    t_bus_req drv_cur;
    int       src_gap = 0;

    always @(posedge i_clk) begin
        bit fire;
        bit idle_ok;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            fire    = s_axis_tvalid && s_axis_tready;
            idle_ok = (cyc_cnt % 300) >= 60 && access_q.size() > 30;
            if (fire) begin
                decode_access(drv_cur);
                acc_cnt++;
            end
            if (fire || !s_axis_tvalid) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (access_q.size() > 0 && idle_ok && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(1, 18) - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (access_q.size() > 0) begin
                    drv_cur = access_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b00000, drv_cur.busy, drv_cur.btn, drv_cur.wdata,
                                      drv_cur.addr};
                    s_axis_tuser  <= drv_cur.wr;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    int snk_gap = 0;

    always @(posedge i_clk) begin
        t_bus_result want;
        bit          stall_ok;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d data %02h ext %05h",
                                              m_axis_tuser[2:0], m_axis_tdata[7:0],
                                              m_axis_tdata[24:8]));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_axis_tuser[2:0] !== want.kind || m_axis_tdata[7:0] !== want.data ||
                        m_axis_tdata[24:8] !== want.ext || m_axis_tuser[3] !== want.rs ||
                        m_axis_tlast !== want.last)
                        report_mismatch($sformatf(
                            "got k%0d d%02h e%05h rs%0b l%0b, want k%0d d%02h e%05h rs%0b l%0b",
                            m_axis_tuser[2:0], m_axis_tdata[7:0], m_axis_tdata[24:8],
                            m_axis_tuser[3], m_axis_tlast, want.kind, want.data, want.ext,
                            want.rs, want.last));
                end
            end
            stall_ok = (cyc_cnt % 250) >= 50 && access_q.size() > 30;
            if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else if (stall_ok && $urandom_range(0, 7) == 0) begin
                snk_gap = $urandom_range(1, 18) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        wait (cyc_cnt >= RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        build_directed();
        build_random(94);
        req_total = access_q.size();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (acc_cnt == req_total);
        wait (decoded_q.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0 && decoded_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
